// ===== sv/rrts_pkg.sv =====
`default_nettype none
package rrts_pkg;

  localparam int unsigned ThreadsDef = 16;
  localparam int unsigned QuantumW = 20;
  localparam logic [QuantumW-1:0] QuantumReset = 20'd1000;

  localparam logic [2:0] ModeTick = 3'd0;
  localparam logic [2:0] ModeSpawn = 3'd1;
  localparam logic [2:0] ModeTerm = 3'd2;
  localparam logic [2:0] ModeBlock = 3'd3;
  localparam logic [2:0] ModeResume = 3'd4;
  localparam logic [2:0] ModeSleep = 3'd5;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatErr = 2'd1;
  localparam logic [1:0] StatHalt = 2'd2;

  typedef enum logic [2:0] {
    TS_READY = 3'd0,
    TS_RUNNING = 3'd1,
    TS_BLOCKED = 3'd2,
    TS_SLEEP = 3'd3,
    TS_SLEEP_BLOCKED = 3'd4
  } tstate_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_EXEC,
    OP_REMOVE,
    OP_WAKE,
    OP_REQUEUE,
    OP_DISPATCH,
    OP_FINISH
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REMOVE,
    S_WAKE,
    S_REQUEUE,
    S_DISPATCH,
    S_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic rem_done;
    logic wake_last;
    logic need_sw;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

// ===== sv/rrts_ctrl.sv =====
`default_nettype none
module rrts_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire rrts_pkg::stat_t stat_i,
  output rrts_pkg::cmd_t      cmd_o
);
  import rrts_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_REMOVE;
      S_REMOVE: begin
        if (stat_i.rem_done) state_d = stat_i.need_sw ? S_WAKE : S_FINISH;
      end
      S_WAKE: begin
        if (stat_i.wake_last) state_d = S_REQUEUE;
      end
      S_REQUEUE: state_d = S_DISPATCH;
      S_DISPATCH: state_d = S_FINISH;
      S_FINISH: begin
        if (!stat_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_EXEC: cmd_o.op = OP_EXEC;
      S_REMOVE: cmd_o.op = OP_REMOVE;
      S_WAKE: cmd_o.op = OP_WAKE;
      S_REQUEUE: cmd_o.op = OP_REQUEUE;
      S_DISPATCH: cmd_o.op = OP_DISPATCH;
      S_FINISH: cmd_o.op = OP_FINISH;
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/rrts_dp.sv =====
`default_nettype none
module rrts_dp #(
  parameter int unsigned Threads = rrts_pkg::ThreadsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rrts_pkg::cmd_t              cmd_i,
  output rrts_pkg::stat_t                  stat_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [rrts_pkg::QuantumW-1:0] cfg_data_i,
  input  wire logic [2:0]                  mode_i,
  input  wire logic [3:0]                  thread_id_i,
  input  wire logic [15:0]                 sleep_quantums_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic [1:0]                       status_o,
  output logic [3:0]                       result_thread_o,
  output logic [3:0]                       running_thread_o,
  output logic                             switched_o,
  output logic [31:0]                      quanta_started_o,
  output logic [31:0]                      thread_quantums_o,
  output logic                             thread_valid_o
);
  import rrts_pkg::*;

  localparam int unsigned IdW = $clog2(Threads);
  localparam int unsigned CntW = $clog2(Threads + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(Threads);
  localparam logic [CntW-1:0] IdxLast = CntW'(Threads - 1);

  logic [QuantumW-1:0] qt_q;
  tstate_e             ts_q [Threads];
  tstate_e             ts_d [Threads];
  logic                use_q [Threads];
  logic                use_d [Threads];
  logic [31:0]         qc_q [Threads];
  logic [31:0]         qc_d [Threads];
  logic [31:0]         wk_q [Threads];
  logic [31:0]         wk_d [Threads];
  logic [IdW-1:0]      ff_q [Threads];
  logic [IdW-1:0]      ff_d [Threads];
  logic [CntW-1:0]     cnt_q, cnt_d, idx_q, idx_d, wr_q, wr_d;
  logic [IdW-1:0]      run_q, run_d;
  logic [31:0]         tot_q, tot_d;
  logic [QuantumW-1:0] tick_q, tick_d;
  logic                halt_q, halt_d;
  logic [2:0]          mode_q;
  logic [3:0]          tid_q;
  logic [15:0]         nq_q;
  logic [1:0]          st_q, st_d;
  logic [3:0]          rth_q, rth_d;
  logic                sw_q, sw_d, rem_q, rem_d;
  logic                ov_q;
  logic [1:0]          o_st_q;
  logic [3:0]          o_rth_q, o_run_q;
  logic                o_sw_q, o_tv_q;
  logic [31:0]         o_tot_q, o_tq_q;

  logic [IdW-1:0]      tix, fnd, nxt, pid;
  logic                ok_id, used, fnd_ok, push;
  logic [QuantumW-1:0] lim;

  assign ok_id = {28'd0, tid_q} < 32'(Threads);
  assign tix = IdW'(tid_q);
  assign used = ok_id && use_q[tix];
  assign lim = (qt_q == '0) ? QuantumW'(1) : qt_q;

  always_comb begin
    fnd = '0;
    fnd_ok = 1'b0;
    for (int k = Threads - 1; k >= 1; k--) begin
      if (!use_q[k]) begin
        fnd = IdW'(k);
        fnd_ok = 1'b1;
      end
    end
  end

  assign stat_o.rem_done = !rem_q || (idx_q >= cnt_q);
  assign stat_o.wake_last = (idx_q == IdxLast);
  assign stat_o.need_sw = sw_q;
  assign stat_o.out_busy = ov_q && !out_ready_i;

  always_comb begin
    ts_d = ts_q;
    use_d = use_q;
    qc_d = qc_q;
    wk_d = wk_q;
    ff_d = ff_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    wr_d = wr_q;
    run_d = run_q;
    tot_d = tot_q;
    tick_d = tick_q;
    halt_d = halt_q;
    st_d = st_q;
    rth_d = rth_q;
    sw_d = sw_q;
    rem_d = rem_q;
    push = 1'b0;
    pid = '0;
    nxt = '0;
    case (cmd_i.op)
      OP_EXEC: begin
        st_d = StatOk;
        rth_d = tid_q;
        sw_d = 1'b0;
        rem_d = 1'b0;
        idx_d = '0;
        wr_d = '0;
        if (halt_q) begin
          st_d = StatHalt;
        end else begin
          unique case (mode_q)
            ModeTick: begin
              tick_d = tick_q + QuantumW'(1);
              sw_d = (tick_d >= lim);
            end
            ModeSpawn: begin
              if (!fnd_ok) begin
                st_d = StatErr;
                rth_d = 4'd0;
              end else begin
                use_d[fnd] = 1'b1;
                ts_d[fnd] = TS_READY;
                qc_d[fnd] = '0;
                push = 1'b1;
                pid = fnd;
                rth_d = 4'(fnd);
              end
            end
            ModeTerm: begin
              if (tid_q == 4'd0) begin
                for (int k = 1; k < Threads; k++) begin
                  use_d[k] = 1'b0;
                  ts_d[k] = TS_BLOCKED;
                  wk_d[k] = '0;
                end
                wk_d[0] = '0;
                cnt_d = '0;
                run_d = '0;
                halt_d = 1'b1;
                st_d = StatHalt;
              end else if (!used) begin
                st_d = StatErr;
              end else begin
                ts_d[tix] = TS_BLOCKED;
                wk_d[tix] = '0;
                use_d[tix] = 1'b0;
                rem_d = 1'b1;
                sw_d = (tix == run_q);
              end
            end
            ModeBlock: begin
              if (tid_q == 4'd0 || !used) begin
                st_d = StatErr;
              end else if (ts_q[tix] == TS_BLOCKED) begin
                st_d = StatOk;
              end else if (tix == run_q) begin
                ts_d[tix] = TS_BLOCKED;
                sw_d = 1'b1;
              end else begin
                if (ts_q[tix] == TS_SLEEP || ts_q[tix] == TS_SLEEP_BLOCKED) begin
                  ts_d[tix] = TS_SLEEP_BLOCKED;
                end else begin
                  ts_d[tix] = TS_BLOCKED;
                end
                rem_d = 1'b1;
              end
            end
            ModeResume: begin
              if (!used) begin
                st_d = StatErr;
              end else if (ts_q[tix] == TS_BLOCKED) begin
                ts_d[tix] = TS_READY;
                push = 1'b1;
                pid = tix;
              end else if (ts_q[tix] == TS_SLEEP_BLOCKED) begin
                ts_d[tix] = TS_SLEEP;
              end
            end
            ModeSleep: begin
              if (run_q == '0 || nq_q == 16'd0) begin
                st_d = StatErr;
              end else begin
                wk_d[run_q] = {16'd0, nq_q} + tot_q;
                ts_d[run_q] = TS_SLEEP;
                sw_d = 1'b1;
              end
            end
            default: st_d = StatErr;
          endcase
        end
      end
      OP_REMOVE: begin
        if (rem_q && idx_q < cnt_q) begin
          if (ff_q[idx_q[IdW-1:0]] != tix) begin
            ff_d[wr_q[IdW-1:0]] = ff_q[idx_q[IdW-1:0]];
            wr_d = wr_q + CntW'(1);
          end
          idx_d = idx_q + CntW'(1);
        end else begin
          if (rem_q) cnt_d = wr_q;
          idx_d = '0;
        end
      end
      OP_WAKE: begin
        if (wk_q[idx_q[IdW-1:0]] != '0 && wk_q[idx_q[IdW-1:0]] == tot_q) begin
          if (ts_q[idx_q[IdW-1:0]] == TS_SLEEP_BLOCKED) begin
            ts_d[idx_q[IdW-1:0]] = TS_BLOCKED;
          end else if (ts_q[idx_q[IdW-1:0]] == TS_SLEEP) begin
            ts_d[idx_q[IdW-1:0]] = TS_READY;
            push = 1'b1;
            pid = idx_q[IdW-1:0];
          end
          wk_d[idx_q[IdW-1:0]] = '0;
        end
        idx_d = stat_o.wake_last ? '0 : idx_q + CntW'(1);
      end
      OP_REQUEUE: begin
        tot_d = tot_q + 32'd1;
        if (ts_q[run_q] == TS_RUNNING) begin
          ts_d[run_q] = TS_READY;
          push = 1'b1;
          pid = run_q;
        end
      end
      OP_DISPATCH: begin
        if (cnt_q != '0) begin
          nxt = ff_q[0];
          for (int k = 0; k < Threads - 1; k++) begin
            ff_d[k] = ff_q[k+1];
          end
          cnt_d = cnt_q - CntW'(1);
        end
        if (32'(nxt) >= 32'(Threads)) nxt = '0;
        run_d = nxt;
        ts_d[nxt] = TS_RUNNING;
        qc_d[nxt] = qc_q[nxt] + 32'd1;
        tick_d = '0;
      end
      default: begin
      end
    endcase
    if (push && cnt_q < CntMax) begin
      ff_d[cnt_q[IdW-1:0]] = pid;
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qt_q <= QuantumReset;
      for (int k = 0; k < Threads; k++) begin
        ts_q[k] <= (k == 0) ? TS_RUNNING : TS_BLOCKED;
        use_q[k] <= 1'b0;
        qc_q[k] <= (k == 0) ? 32'd1 : 32'd0;
        wk_q[k] <= '0;
      end
      cnt_q <= '0;
      idx_q <= '0;
      wr_q <= '0;
      run_q <= '0;
      tot_q <= 32'd1;
      tick_q <= '0;
      halt_q <= 1'b0;
      sw_q <= 1'b0;
      rem_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) qt_q <= cfg_data_i;
      ts_q <= ts_d;
      use_q <= use_d;
      qc_q <= qc_d;
      wk_q <= wk_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      wr_q <= wr_d;
      run_q <= run_d;
      tot_q <= tot_d;
      tick_q <= tick_d;
      halt_q <= halt_d;
      sw_q <= sw_d;
      rem_q <= rem_d;
      if (cmd_i.op == OP_FINISH && !stat_o.out_busy) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ff_q <= ff_d;
    st_q <= st_d;
    rth_q <= rth_d;
    if (cmd_i.load) begin
      mode_q <= mode_i;
      tid_q <= thread_id_i;
      nq_q <= sleep_quantums_i;
    end
    if (cmd_i.op == OP_FINISH && !stat_o.out_busy) begin
      o_st_q <= st_q;
      o_rth_q <= rth_q;
      o_run_q <= 4'(run_q);
      o_sw_q <= sw_q;
      o_tot_q <= tot_q;
      o_tq_q <= ok_id ? qc_q[tix] : 32'd0;
      o_tv_q <= (tid_q == 4'd0) || used;
    end
  end

  assign out_valid_o = ov_q;
  assign status_o = o_st_q;
  assign result_thread_o = o_rth_q;
  assign running_thread_o = o_run_q;
  assign switched_o = o_sw_q;
  assign quanta_started_o = o_tot_q;
  assign thread_quantums_o = o_tq_q;
  assign thread_valid_o = o_tv_q;

endmodule
`default_nettype wire

// ===== sv/round_robin_thread_scheduler_unit.sv =====
// Channel   Direction  Handshake                    Contents
// in        input      in_valid_i / in_ready_o      mode, thread_id, sleep_quantums
// out       output     out_valid_o / out_ready_i    status .. thread_valid
// cfg       input      quantum_ticks_we_i           quantum_ticks_i
//
// One word is processed at a time. A word without a switch passes through the exec,
// remove and finish states; a removal from the ready queue walks the queue entry by
// entry, and a switch adds a wakeup scan over every thread slot, then requeue and
// dispatch. The result register frees the core once loaded; the core then stalls
// only when the next result is ready and the previous word is still not taken.
// Reset is asynchronous and needs no clearing pass.
`default_nettype none
module round_robin_thread_scheduler_unit #(
  parameter int unsigned Threads = rrts_pkg::ThreadsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [2:0]                    mode_i,
  input  wire logic [3:0]                    thread_id_i,
  input  wire logic [15:0]                   sleep_quantums_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         status_o,
  output logic [3:0]                         result_thread_o,
  output logic [3:0]                         running_thread_o,
  output logic                               switched_o,
  output logic [31:0]                        quanta_started_o,
  output logic [31:0]                        thread_quantums_o,
  output logic                               thread_valid_o,
  input  wire logic                          quantum_ticks_we_i,
  input  wire logic [rrts_pkg::QuantumW-1:0] quantum_ticks_i
);
  import rrts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rrts_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .stat_i(stat),
    .cmd_o(cmd)
  );

  rrts_dp #(.Threads(Threads)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i(cmd),
    .stat_o(stat),
    .cfg_we_i(quantum_ticks_we_i),
    .cfg_data_i(quantum_ticks_i),
    .mode_i,
    .thread_id_i,
    .sleep_quantums_i,
    .out_ready_i,
    .out_valid_o,
    .status_o,
    .result_thread_o,
    .running_thread_o,
    .switched_o,
    .quanta_started_o,
    .thread_quantums_o,
    .thread_valid_o
  );

endmodule
`default_nettype wire

// ===== sv/rrts_checker.sv =====
`default_nettype none
module rrts_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] status_o,
  input wire logic [3:0] running_thread_o,
  input wire logic       switched_o
);
  import rrts_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result word dropped while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == StatOk || status_o == StatErr || status_o == StatHalt)
    else $error("undefined status code");

  a_switch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && switched_o |-> status_o == StatOk)
    else $error("switch reported with a failing status");

  a_halt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatHalt |-> !switched_o && running_thread_o == 4'd0)
    else $error("halted block still schedules");

endmodule

bind round_robin_thread_scheduler_unit rrts_checker u_rrts_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .status_o(status_o),
  .running_thread_o(running_thread_o),
  .switched_o(switched_o)
);
`default_nettype wire

// ===== dv/round_robin_thread_scheduler_unit_tb.sv =====
`default_nettype none
module round_robin_thread_scheduler_unit_tb;
  import rrts_pkg::*;

  localparam int NThr = 16;
  localparam logic [2:0] ModeBad6 = 3'd6;
  localparam logic [2:0] ModeBad7 = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  rthread;
    logic [3:0]  running;
    logic        switched;
    logic [31:0] total;
    logic [31:0] tquant;
    logic        tvalid;
  } sched_word_t;

  typedef struct packed {
    logic        pinned;
    logic [1:0]  pin_status;
    sched_word_t w;
  } sched_expect_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  tid;
    logic [15:0] nq;
    logic        pinned;
    logic [1:0]  status;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] mode_i = ModeTick;
  logic [3:0] thread_id_i = '0;
  logic [15:0] sleep_quantums_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [3:0] result_thread_o;
  logic [3:0] running_thread_o;
  logic switched_o;
  logic [31:0] quanta_started_o;
  logic [31:0] thread_quantums_o;
  logic thread_valid_o;
  logic quantum_ticks_we_i = 1'b0;
  logic [QuantumW-1:0] quantum_ticks_i = '0;

  round_robin_thread_scheduler_unit u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .thread_id_i, .sleep_quantums_i,
    .out_valid_o, .out_ready_i, .status_o, .result_thread_o, .running_thread_o, .switched_o,
    .quanta_started_o, .thread_quantums_o, .thread_valid_o, .quantum_ticks_we_i,
    .quantum_ticks_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the scheduler state.
  tstate_e     thr_state [NThr];
  logic        thr_used [NThr];
  logic [31:0] thr_quant [NThr];
  logic [31:0] thr_wake [NThr];
  logic [3:0]  ready_q [$];
  logic [3:0]  run_id;
  logic [31:0] total_cnt;
  logic [19:0] tick_cnt;
  logic        halted;
  logic [19:0] quantum_ticks;

  sched_expect_t expected_q [$];
  int errors = 0;
  int words_sent = 0;
  int switches_seen = 0;
  int err_status_seen = 0;
  logic cur_pinned = 1'b0;
  logic [1:0] cur_status = StatOk;
  int burst_left = 0;
  logic hold_req = 1'b0;

  task automatic shadow_reset();
    for (int i = 0; i < NThr; i++) begin
      thr_state[i] = (i == 0) ? TS_RUNNING : TS_BLOCKED;
      thr_used[i] = 1'b0;
      thr_quant[i] = (i == 0) ? 32'd1 : 32'd0;
      thr_wake[i] = '0;
    end
    ready_q.delete();
    run_id = '0;
    total_cnt = 32'd1;
    tick_cnt = '0;
    halted = 1'b0;
    quantum_ticks = QuantumReset;
  endtask

  function automatic void ready_push(input logic [3:0] id);
    if (ready_q.size() < NThr) ready_q.insert(ready_q.size(), id);
  endfunction

  function automatic void ready_drop(input logic [3:0] id);
    for (int i = ready_q.size() - 1; i >= 0; i--) begin
      if (ready_q[i] == id) ready_q.delete(i);
    end
  endfunction

  function automatic void context_switch();
    logic [3:0] nxt;
    nxt = '0;
    for (int i = 0; i < NThr; i++) begin
      if (thr_wake[i] != 0 && thr_wake[i] == total_cnt) begin
        if (thr_state[i] == TS_SLEEP_BLOCKED) begin
          thr_state[i] = TS_BLOCKED;
        end else if (thr_state[i] == TS_SLEEP) begin
          thr_state[i] = TS_READY;
          ready_push(4'(i));
        end
        thr_wake[i] = '0;
      end
    end
    total_cnt++;
    if (thr_state[run_id] == TS_RUNNING) begin
      thr_state[run_id] = TS_READY;
      ready_push(run_id);
    end
    if (ready_q.size() > 0) begin
      nxt = ready_q[0];
      ready_q.delete(0);
    end
    run_id = nxt;
    thr_state[nxt] = TS_RUNNING;
    thr_quant[nxt]++;
    tick_cnt = '0;
  endfunction

  function automatic sched_word_t schedule_event(input logic [2:0] mode, input logic [3:0] tid,
                                                 input logic [15:0] nq);
    sched_word_t w;
    logic [19:0] lim;
    logic [3:0] found;
    w = '0;
    w.rthread = tid;
    if (halted) begin
      w.status = StatHalt;
    end else begin
      case (mode)
        ModeTick: begin
          lim = (quantum_ticks == 0) ? 20'd1 : quantum_ticks;
          tick_cnt = tick_cnt + 20'd1;
          if (tick_cnt >= lim) begin
            context_switch();
            w.switched = 1'b1;
          end
        end
        ModeSpawn: begin
          found = '0;
          for (int i = NThr - 1; i >= 1; i--) begin
            if (!thr_used[i]) found = 4'(i);
          end
          if (found == 0) begin
            w.status = StatErr;
            w.rthread = '0;
          end else begin
            thr_used[found] = 1'b1;
            thr_state[found] = TS_READY;
            thr_quant[found] = '0;
            ready_push(found);
            w.rthread = found;
          end
        end
        ModeTerm: begin
          if (tid == 0) begin
            for (int i = 1; i < NThr; i++) begin
              thr_used[i] = 1'b0;
              thr_state[i] = TS_BLOCKED;
              thr_wake[i] = '0;
            end
            thr_wake[0] = '0;
            ready_q.delete();
            run_id = '0;
            halted = 1'b1;
            w.status = StatHalt;
          end else if (!thr_used[tid]) begin
            w.status = StatErr;
          end else begin
            ready_drop(tid);
            thr_state[tid] = TS_BLOCKED;
            thr_wake[tid] = '0;
            thr_used[tid] = 1'b0;
            if (tid == run_id) begin
              context_switch();
              w.switched = 1'b1;
            end
          end
        end
        ModeBlock: begin
          if (tid == 0 || !thr_used[tid]) begin
            w.status = StatErr;
          end else if (thr_state[tid] == TS_BLOCKED) begin
            w.status = StatOk;
          end else if (tid == run_id) begin
            thr_state[tid] = TS_BLOCKED;
            context_switch();
            w.switched = 1'b1;
          end else begin
            if (thr_state[tid] == TS_SLEEP || thr_state[tid] == TS_SLEEP_BLOCKED) begin
              thr_state[tid] = TS_SLEEP_BLOCKED;
            end else begin
              thr_state[tid] = TS_BLOCKED;
            end
            ready_drop(tid);
          end
        end
        ModeResume: begin
          if (!thr_used[tid]) begin
            w.status = StatErr;
          end else if (thr_state[tid] == TS_BLOCKED) begin
            thr_state[tid] = TS_READY;
            ready_push(tid);
          end else if (thr_state[tid] == TS_SLEEP_BLOCKED) begin
            thr_state[tid] = TS_SLEEP;
          end
        end
        ModeSleep: begin
          if (run_id == 0 || nq == 0) begin
            w.status = StatErr;
          end else begin
            thr_wake[run_id] = 32'(nq) + total_cnt;
            thr_state[run_id] = TS_SLEEP;
            context_switch();
            w.switched = 1'b1;
          end
        end
        default: w.status = StatErr;
      endcase
    end
    w.running = run_id;
    w.total = total_cnt;
    w.tquant = thr_quant[tid];
    w.tvalid = (tid == 0) || thr_used[tid];
    return w;
  endfunction

  task automatic report(input string fname, input logic [31:0] exp_v, input logic [31:0] act_v);
    $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, fname, exp_v, act_v);
    errors++;
  endtask

  always @(posedge clk_i) begin
    sched_expect_t e;
    sched_word_t act;
    if (rst_ni && out_valid_o && out_ready_i) begin
      act = '{status_o, result_thread_o, running_thread_o, switched_o, quanta_started_o,
              thread_quantums_o, thread_valid_o};
      if (expected_q.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        errors++;
      end else begin
        e = expected_q[0];
        expected_q.delete(0);
        if (e.pinned && act.status != e.pin_status) report("status", e.pin_status, act.status);
        if (act.status != e.w.status) report("status", e.w.status, act.status);
        if (act.rthread != e.w.rthread) report("result_thread", e.w.rthread, act.rthread);
        if (act.running != e.w.running) report("running_thread", e.w.running, act.running);
        if (act.switched != e.w.switched) report("switched", e.w.switched, act.switched);
        if (act.total != e.w.total) report("quanta_started", e.w.total, act.total);
        if (act.tquant != e.w.tquant) report("thread_quantums", e.w.tquant, act.tquant);
        if (act.tvalid != e.w.tvalid) report("thread_valid", e.w.tvalid, act.tvalid);
        if (act.switched) switches_seen++;
        if (act.status == StatErr) err_status_seen++;
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      e.pinned = cur_pinned;
      e.pin_status = cur_status;
      e.w = schedule_event(mode_i, thread_id_i, sleep_quantums_i);
      expected_q.insert(expected_q.size(), e);
    end
  end

  // The receiver stalls on a rotating pattern that is reloaded now and then.
  always @(negedge clk_i) begin
    logic [7:0] pat;
    int left;
    int hold_cnt;
    if (!rst_ni) begin
      pat = 8'hFF;
      left = 0;
      hold_cnt = 0;
      out_ready_i <= 1'b0;
    end else if (hold_req && hold_cnt < 300) begin
      hold_cnt++;
      out_ready_i <= 1'b0;
    end else begin
      if (left == 0) begin
        pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
        left = $urandom_range(16, 96);
      end
      left--;
      pat = {pat[6:0], pat[7]};
      out_ready_i <= pat[0];
      if (!hold_req) hold_cnt = 0;
    end
  end

  task automatic send_word(input logic [2:0] mode, input logic [3:0] tid, input logic [15:0] nq,
                           input logic pinned, input logic [1:0] stat);
    in_valid_i = 1'b1;
    mode_i = mode;
    thread_id_i = tid;
    sleep_quantums_i = nq;
    cur_pinned = pinned;
    cur_status = stat;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
    end
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_quantum(input logic [19:0] v);
    quantum_ticks_i = v;
    quantum_ticks_we_i = 1'b1;
    @(negedge clk_i);
    quantum_ticks_we_i = 1'b0;
    quantum_ticks = v;
  endtask

  function automatic logic [3:0] pick_thread();
    logic [3:0] t;
    t = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) < 7) begin
      for (int k = 0; k < 8; k++) begin
        if (!thr_used[t] && t != 0) t = 4'($urandom_range(1, 15));
      end
    end
    return t;
  endfunction

  task automatic random_words(input int n);
    logic [2:0] m;
    logic [3:0] t;
    logic [15:0] q;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      t = pick_thread();
      q = 16'($urandom_range(1, 4));
      if (r < 35) begin
        m = ModeTick;
      end else if (r < 50) begin
        m = ModeSpawn;
      end else if (r < 58) begin
        m = ModeTerm;
        if (t == 0) t = 4'($urandom_range(1, 15));
        if ($urandom_range(0, 2) == 0) t = run_id;
        if (t == 0) t = 4'd1;
      end else if (r < 70) begin
        m = ModeBlock;
        if ($urandom_range(0, 1) == 0) t = run_id;
      end else if (r < 82) begin
        m = ModeResume;
      end else begin
        m = ModeSleep;
        case ($urandom_range(0, 9))
          0: q = 16'($urandom);
          1: q = 16'hFFFF;
          2: q = 16'd0;
          default: ;
        endcase
      end
      send_word(m, t, q, 1'b0, StatOk);
    end
  endtask

  localparam int NRows = 20;
  stim_row_t dir_rows [NRows] = '{
    '{ModeTick,   4'd0,  16'd0,     1'b1, StatOk},
    '{ModeBlock,  4'd0,  16'd0,     1'b1, StatErr},
    '{ModeResume, 4'd0,  16'd0,     1'b1, StatErr},
    '{ModeSleep,  4'd0,  16'd3,     1'b1, StatErr},
    '{ModeBad6,   4'd3,  16'd0,     1'b1, StatErr},
    '{ModeBad7,   4'd15, 16'hFFFF,  1'b1, StatErr},
    '{ModeTerm,   4'd9,  16'd0,     1'b1, StatErr},
    '{ModeBlock,  4'd5,  16'd0,     1'b1, StatErr},
    '{ModeResume, 4'd15, 16'd0,     1'b1, StatErr},
    '{ModeSpawn,  4'd0,  16'd0,     1'b1, StatOk},
    '{ModeSpawn,  4'd7,  16'd0,     1'b1, StatOk},
    '{ModeBlock,  4'd2,  16'd0,     1'b0, StatOk},
    '{ModeBlock,  4'd2,  16'd0,     1'b1, StatOk},
    '{ModeResume, 4'd2,  16'd0,     1'b0, StatOk},
    '{ModeTick,   4'd1,  16'd0,     1'b0, StatOk},
    '{ModeSleep,  4'd1,  16'd0,     1'b1, StatErr},
    '{ModeSleep,  4'd1,  16'hFFFF,  1'b0, StatOk},
    '{ModeTick,   4'd2,  16'd0,     1'b0, StatOk},
    '{ModeSleep,  4'd2,  16'd1,     1'b0, StatOk},
    '{ModeTerm,   4'd2,  16'd0,     1'b0, StatOk}
  };

  initial begin
    shadow_reset();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    set_quantum(20'd1);
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].mode, dir_rows[i].tid, dir_rows[i].nq, dir_rows[i].pinned,
                dir_rows[i].status);
    end
    random_words(30);
    hold_req = 1'b1;
    random_words(100);
    hold_req = 1'b0;
    wait_idle();
    set_quantum(20'd0);
    random_words(90);
    wait_idle();
    set_quantum(20'd3);
    random_words(100);
    wait_idle();
    set_quantum(20'hFFFFF);
    random_words(100);
    send_word(ModeTerm, 4'd0, 16'd0, 1'b1, StatHalt);
    send_word(ModeSpawn, 4'd0, 16'd0, 1'b1, StatHalt);
    send_word(ModeTick, 4'd4, 16'd0, 1'b1, StatHalt);
    send_word(ModeBad7, 4'd0, 16'd0, 1'b1, StatHalt);
    wait_idle();
    $display("Sent %0d words over quantum settings 1, 0, 3 and max, ending in a halt.",
             words_sent);
    $display("Saw %0d context switches and %0d error results.", switches_seen, err_status_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/rrts_pkg.sv
sv/rrts_ctrl.sv
sv/rrts_dp.sv
sv/round_robin_thread_scheduler_unit.sv
sv/rrts_checker.sv
dv/round_robin_thread_scheduler_unit_tb.sv
